// ----- rtl/csl_pkg.sv -----
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the C source lexer
// Token kinds, error codes, lexer modes, the result record and the
// punctuator table.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

  localparam int unsigned OffW = 20;

  // token kinds
  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_NUMBER  = 3'd1;
  localparam logic [2:0] KIND_STRCHR  = 3'd2;
  localparam logic [2:0] KIND_STREND  = 3'd3;
  localparam logic [2:0] KIND_CHARLIT = 3'd4;
  localparam logic [2:0] KIND_PUNCT   = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;
  localparam logic [2:0] KIND_END     = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NUMBER  = 3'd1;
  localparam logic [2:0] ERR_STRING  = 3'd2;
  localparam logic [2:0] ERR_CHAR    = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN = 3'd4;

  // lexer modes
  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_NUMBER     = 4'd2;
  localparam logic [3:0] M_PUNCT      = 4'd3;
  localparam logic [3:0] M_LINE       = 4'd4;
  localparam logic [3:0] M_BLOCK      = 4'd5;
  localparam logic [3:0] M_BLOCK_STAR = 4'd6;
  localparam logic [3:0] M_STRING     = 4'd7;
  localparam logic [3:0] M_STRING_ESC = 4'd8;
  localparam logic [3:0] M_CHAR_OPEN  = 4'd9;
  localparam logic [3:0] M_CHAR_ESC   = 4'd10;
  localparam logic [3:0] M_CHAR_CLOSE = 4'd11;

  localparam int unsigned NumPunct = 40;

  typedef struct packed {
    logic [2:0]      kind;
    logic [5:0]      pidx;
    logic [63:0]     value;
    logic [OffW-1:0] start;
    logic [OffW-1:0] len;
    logic [2:0]      err;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    logic [1:0] len;
  } punct_t;

  localparam punct_t PunctTable [NumPunct] = '{
    '{8'h2b, 8'h3d, 8'h00, 2'd2}, '{8'h2d, 8'h3d, 8'h00, 2'd2},
    '{8'h2a, 8'h3d, 8'h00, 2'd2}, '{8'h2f, 8'h3d, 8'h00, 2'd2},
    '{8'h2b, 8'h2b, 8'h00, 2'd2}, '{8'h2d, 8'h2d, 8'h00, 2'd2},
    '{8'h3c, 8'h3c, 8'h3d, 2'd3}, '{8'h3e, 8'h3e, 8'h3d, 2'd3},
    '{8'h26, 8'h3d, 8'h00, 2'd2}, '{8'h7c, 8'h3d, 8'h00, 2'd2},
    '{8'h5e, 8'h3d, 8'h00, 2'd2}, '{8'h25, 8'h3d, 8'h00, 2'd2},
    '{8'h3d, 8'h3d, 8'h00, 2'd2}, '{8'h21, 8'h3d, 8'h00, 2'd2},
    '{8'h3c, 8'h3d, 8'h00, 2'd2}, '{8'h3e, 8'h3d, 8'h00, 2'd2},
    '{8'h2d, 8'h3e, 8'h00, 2'd2}, '{8'h26, 8'h26, 8'h00, 2'd2},
    '{8'h7c, 8'h7c, 8'h00, 2'd2}, '{8'h3c, 8'h3c, 8'h00, 2'd2},
    '{8'h3e, 8'h3e, 8'h00, 2'd2}, '{8'h2e, 8'h2e, 8'h2e, 2'd3},
    '{8'h23, 8'h23, 8'h00, 2'd2}, '{8'h21, 8'h00, 8'h00, 2'd1},
    '{8'h22, 8'h00, 8'h00, 2'd1}, '{8'h27, 8'h00, 8'h00, 2'd1},
    '{8'h2b, 8'h00, 8'h00, 2'd1}, '{8'h2d, 8'h00, 8'h00, 2'd1},
    '{8'h2a, 8'h00, 8'h00, 2'd1}, '{8'h2f, 8'h00, 8'h00, 2'd1},
    '{8'h2e, 8'h00, 8'h00, 2'd1}, '{8'h2c, 8'h00, 8'h00, 2'd1},
    '{8'h28, 8'h00, 8'h00, 2'd1}, '{8'h29, 8'h00, 8'h00, 2'd1},
    '{8'h5b, 8'h00, 8'h00, 2'd1}, '{8'h5d, 8'h00, 8'h00, 2'd1},
    '{8'h7b, 8'h00, 8'h00, 2'd1}, '{8'h7d, 8'h00, 8'h00, 2'd1},
    '{8'h23, 8'h00, 8'h00, 2'd1}, '{8'h3b, 8'h00, 8'h00, 2'd1}
  };

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  // {valid, decoded value}
  function automatic logic [8:0] decode_escape(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6e:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'd92:   r = {1'b1, 8'd92};
      8'd39:   r = {1'b1, 8'd39};
      8'd34:   r = {1'b1, 8'd34};
      8'd63:   r = {1'b1, 8'd63};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/c_source_lexer.sv -----
// ----------------------------------------------------------------------------
// c_source_lexer: streaming C source lexer
// Takes one source byte per request and emits tokens into a small result
// queue; whitespace and comments are skipped.
// ----------------------------------------------------------------------------
//  channel | signals                       | direction
//  text    | in_valid_i/in_ready_o         | one source byte per request
//  token   | out_valid_o/out_ready_i       | one token record per request
//
//  One byte per cycle while in_ready_o is high; the lexer state updates in the cycle a byte is taken.
//  A byte gives up to two tokens, written into a four-entry result queue.
//  in_ready_o drops while fewer than two queue slots are free, so bytes that
//  give two tokens can stall the input until a waiting sink drains the queue.
//  Reset clears the lexer state and the queue; an error halts until reset.
`default_nettype none

module c_source_lexer #(
  parameter int unsigned MAX_TEXT_LEN = 1048576
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                text_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2:0]                     token_kind_o,
  output logic [5:0]                     punct_index_o,
  output logic [63:0]                    token_value_o,
  output logic [csl_pkg::OffW-1:0]       start_offset_o,
  output logic [csl_pkg::OffW-1:0]       token_length_o,
  output logic [2:0]                     error_code_o,
  output logic                           last_of_run_o
);
  import csl_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_TEXT_LEN);
  localparam logic [PosW:0] MaxLen = (PosW+1)'(MAX_TEXT_LEN);
  localparam logic [PosW-1:0] LastPos = PosW'(MAX_TEXT_LEN - 1);

  typedef struct packed {
    logic [3:0]      mode;
    logic [7:0]      la0;
    logic [7:0]      la1;
    logic [1:0]      lac;
    logic [63:0]     acc;
    logic [7:0]      chv;
    logic [PosW-1:0] ts;
    logic            halted;
  } lex_st_t;

  typedef struct packed {
    lex_st_t st;
    logic    rv;
    res_t    res;
    logic    again;
    logic    ended;
  } step_t;

  function automatic logic [PosW:0] dist_f(logic [PosW-1:0] p, logic [PosW-1:0] ts);
    if (p >= ts) return {1'b0, p} - {1'b0, ts};
    return {1'b0, p} + MaxLen - {1'b0, ts};
  endfunction

  function automatic res_t mk_res(logic [2:0] kind, logic [5:0] pidx, logic [63:0] value,
                                  logic [PosW-1:0] start, logic [PosW:0] len,
                                  logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.pidx  = pidx;
    r.value = value;
    r.start = OffW'(start);
    r.len   = OffW'(len);
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic step_t mk_fail(step_t r, logic [2:0] code, logic [PosW:0] len);
    step_t o;
    o = r;
    o.rv = 1'b1;
    o.res = mk_res(KIND_ERROR, 6'd0, 64'd0, r.st.ts, len, code);
    o.st.halted = 1'b1;
    o.st.mode = M_IDLE;
    o.st.lac = 2'd0;
    return o;
  endfunction

  function automatic step_t punct_eval(step_t r, logic [7:0] b0, logic [7:0] b1,
                                       logic [7:0] b2, logic [1:0] n);
    step_t o;
    logic found;
    logic ok;
    punct_t e;
    o = r;
    found = 1'b0;
    if (n >= 2'd2 && b0 == 8'h2f && (b1 == 8'h2f || b1 == 8'h2a)) begin
      o.st.mode = (b1 == 8'h2f) ? M_LINE : M_BLOCK;
      o.st.lac = 2'd0;
      found = 1'b1;
    end
    for (int i = 0; i < NumPunct; i++) begin
      e = PunctTable[i];
      ok = (e.s0 == b0) && (e.len < 2'd2 || n < 2'd2 || e.s1 == b1) &&
           (e.len < 2'd3 || n < 2'd3 || e.s2 == b2);
      if (!found && ok) begin
        found = 1'b1;
        if (e.len > n) begin
          // hold the prefix and wait for more bytes
          o.st.la0 = b0;
          o.st.la1 = (n > 2'd1) ? b1 : 8'd0;
          o.st.lac = n;
          o.st.mode = M_PUNCT;
        end else begin
          o.rv = 1'b1;
          o.res = mk_res(KIND_PUNCT, 6'(i), 64'd0, r.st.ts, (PosW+1)'(e.len), ERR_NONE);
          o.st.mode = M_IDLE;
          o.st.lac = 2'd0;
          o.again = e.len < n;
        end
      end
    end
    if (!found) o = mk_fail(r, ERR_UNKNOWN, (PosW+1)'(1));
    return o;
  endfunction

  function automatic step_t lex_process(lex_st_t s, logic [7:0] c, logic [PosW-1:0] p);
    step_t r;
    logic [8:0] esc;
    logic [1:0] n;
    r.st = s;
    r.rv = 1'b0;
    r.res = '0;
    r.again = 1'b0;
    r.ended = 1'b0;
    esc = decode_escape(c);
    n = (s.lac > 2'd2) ? 2'd2 : s.lac;
    case (s.mode)
      M_IDLE: begin
        if (c == 8'd0) begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_END, 6'd0, 64'd0, p, '0, ERR_NONE);
          r.ended = 1'b1;
        end else if (!is_space(c)) begin
          r.st.ts = p;
          if (is_alpha(c) || c == 8'h5f) r.st.mode = M_IDENT;
          else if (is_digit(c)) begin
            r.st.mode = M_NUMBER;
            r.st.acc = 64'(c - 8'h30);
          end else if (c == 8'h2e) r = mk_fail(r, ERR_NUMBER, (PosW+1)'(1));
          else if (c == 8'd34) r.st.mode = M_STRING;
          else if (c == 8'd39) r.st.mode = M_CHAR_OPEN;
          else r = punct_eval(r, c, 8'd0, 8'd0, 2'd1);
        end
      end
      M_IDENT: begin
        if (!(is_alpha(c) || is_digit(c) || c == 8'h5f)) begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_IDENT, 6'd0, 64'd0, s.ts, dist_f(p, s.ts), ERR_NONE);
          r.st.mode = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          r.st.acc = (s.acc << 3) + (s.acc << 1) + 64'(c - 8'h30);
        end else if (!is_alpha(c)) begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_NUMBER, 6'd0, s.acc, s.ts, dist_f(p, s.ts), ERR_NONE);
          r.st.mode = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_PUNCT: begin
        if (n == 2'd0) r = punct_eval(r, c, 8'd0, 8'd0, 2'd1);
        else if (n == 2'd1) r = punct_eval(r, s.la0, c, 8'd0, 2'd2);
        else r = punct_eval(r, s.la0, s.la1, c, 2'd3);
      end
      M_LINE: begin
        if (c == 8'd0) begin
          r.st.mode = M_IDLE;
          r.again = 1'b1;
        end else if (c == 8'd10) r.st.mode = M_IDLE;
      end
      M_BLOCK: begin
        if (c == 8'd0) begin
          r.st.mode = M_IDLE;
          r.again = 1'b1;
        end else if (c == 8'h2a) r.st.mode = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        if (c == 8'd0) begin
          r.st.mode = M_IDLE;
          r.again = 1'b1;
        end else if (c == 8'h2f) r.st.mode = M_IDLE;
        else if (c != 8'h2a) r.st.mode = M_BLOCK;
      end
      M_STRING: begin
        if (c == 8'd0) r = mk_fail(r, ERR_STRING, dist_f(p, s.ts) + 1'b1);
        else if (c == 8'd34) begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_STREND, 6'd0, 64'd0, s.ts, dist_f(p, s.ts) + 1'b1, ERR_NONE);
          r.st.mode = M_IDLE;
        end else if (c == 8'd92) r.st.mode = M_STRING_ESC;
        else begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_STRCHR, 6'd0, 64'(c), p, (PosW+1)'(1), ERR_NONE);
        end
      end
      M_STRING_ESC: begin
        if (!esc[8]) r = mk_fail(r, ERR_STRING, dist_f(p, s.ts) + 1'b1);
        else begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_STRCHR, 6'd0, 64'(esc[7:0]),
                         (p == '0) ? LastPos : p - PosW'(1), (PosW+1)'(2), ERR_NONE);
          r.st.mode = M_STRING;
        end
      end
      M_CHAR_OPEN: begin
        if (c == 8'd0 || c == 8'd39) r = mk_fail(r, ERR_CHAR, dist_f(p, s.ts) + 1'b1);
        else if (c == 8'd92) r.st.mode = M_CHAR_ESC;
        else begin
          r.st.chv = c;
          r.st.mode = M_CHAR_CLOSE;
        end
      end
      M_CHAR_ESC: begin
        if (!esc[8]) r = mk_fail(r, ERR_CHAR, dist_f(p, s.ts) + 1'b1);
        else begin
          r.st.chv = esc[7:0];
          r.st.mode = M_CHAR_CLOSE;
        end
      end
      M_CHAR_CLOSE: begin
        if (c != 8'd39) r = mk_fail(r, ERR_CHAR, dist_f(p, s.ts) + 1'b1);
        else begin
          r.rv = 1'b1;
          r.res = mk_res(KIND_CHARLIT, 6'd0, 64'(s.chv), s.ts, dist_f(p, s.ts) + 1'b1,
                         ERR_NONE);
          r.st.mode = M_IDLE;
        end
      end
      default: begin
        r.st.mode = M_IDLE;
        r.again = 1'b1;
      end
    endcase
    return r;
  endfunction

  lex_st_t         st_q, st_d;
  logic [PosW-1:0] pos_q, pos_d;
  res_t            fifo_q [4];
  logic [1:0]      wr_q, rd_q;
  logic [2:0]      cnt_q, cnt_d;
  step_t           r1, r2;
  res_t            e0, e1;
  logic [1:0]      n_push;
  logic            in_acc, out_acc, ended;

  assign in_ready_o  = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    r1 = lex_process(st_q, text_byte_i, pos_q);
    if (r1.again && !r1.st.halted) begin
      r2 = lex_process(r1.st, text_byte_i, pos_q);
    end else begin
      r2 = r1;
      r2.rv = 1'b0;
      r2.again = 1'b0;
      r2.ended = 1'b0;
    end
    ended = r1.ended || r2.ended;
    e0 = r1.res;
    e1 = r2.res;
    e1.last = 1'b1;
    n_push = 2'd0;
    if (r1.rv && r2.rv) n_push = 2'd2;
    else if (r1.rv) begin
      n_push = 2'd1;
      e0.last = 1'b1;
    end else if (r2.rv) begin
      n_push = 2'd1;
      e0 = e1;
    end
    if (!in_acc || st_q.halted) n_push = 2'd0;

    st_d  = st_q;
    pos_d = pos_q;
    if (in_acc && !st_q.halted) begin
      if (ended) begin
        st_d  = '0;
        pos_d = '0;
      end else begin
        st_d  = r2.st;
        pos_d = ({1'b0, pos_q} + 1'b1 == MaxLen) ? '0 : pos_q + PosW'(1);
      end
    end
    cnt_d = cnt_q + 3'(n_push) - 3'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      pos_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + 2'(out_acc);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) fifo_q[wr_q] <= e0;
    if (n_push == 2'd2) fifo_q[wr_q + 2'd1] <= e1;
  end

  assign token_kind_o   = fifo_q[rd_q].kind;
  assign punct_index_o  = fifo_q[rd_q].pidx;
  assign token_value_o  = fifo_q[rd_q].value;
  assign start_offset_o = fifo_q[rd_q].start;
  assign token_length_o = fifo_q[rd_q].len;
  assign error_code_o   = fifo_q[rd_q].err;
  assign last_of_run_o  = fifo_q[rd_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.halted |-> n_push == 2'd0)
    else $error("tokens pushed while halted");
  a_end_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !st_q.halted && ended) |=> (pos_q == '0 && st_q.mode == M_IDLE))
    else $error("position not rewound after end of text");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the C source lexer
// Streams source text into the lexer byte by byte and predicts every token
// with a behavioral lexer of its own. Each token that comes out is compared
// field by field against the oldest predicted token. Both sides idle at random,
// and the token side holds off once for a long stretch. The run ends with
// one error, after which the lexer must stay silent.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import csl_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomBytes = 100;
  localparam logic [7:0] Quote = 8'd34;
  localparam logic [7:0] Apos = 8'd39;
  localparam logic [7:0] Bslash = 8'd92;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  pidx;
    logic [63:0] value;
    logic [19:0] start;
    logic [19:0] len;
    logic [2:0]  err;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic [5:0]  punct_index_o;
  logic [63:0] token_value_o;
  logic [19:0] start_offset_o;
  logic [19:0] token_length_o;
  logic [2:0]  error_code_o;
  logic        last_of_run_o;

  c_source_lexer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .text_byte_i,
    .out_valid_o, .out_ready_i, .token_kind_o, .punct_index_o, .token_value_o,
    .start_offset_o, .token_length_o, .error_code_o, .last_of_run_o
  );

  always #2 clk_i = ~clk_i;

  // lexer state of the predictor
  logic [3:0]  lx_mode;
  logic [7:0]  la_byte [2];
  logic [1:0]  la_cnt;
  logic [63:0] num_acc;
  logic [7:0]  lit_code;
  logic [19:0] tok_start;
  logic [19:0] byte_pos;
  bit          halted;
  bit          text_done;

  token_t      step_tokens[$];
  token_t      expected_tokens[$];
  logic [7:0]  src[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;

  function automatic void clear_lexer();
    lx_mode = M_IDLE;
    la_byte[0] = 8'd0;
    la_byte[1] = 8'd0;
    la_cnt = 2'd0;
    num_acc = 64'd0;
    lit_code = 8'd0;
    tok_start = 20'd0;
    byte_pos = 20'd0;
    halted = 1'b0;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit decimal(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // {known, decoded code}
  function automatic logic [8:0] unescape(logic [7:0] c);
    case (c)
      "a":     return {1'b1, 8'd7};
      "b":     return {1'b1, 8'd8};
      "f":     return {1'b1, 8'd12};
      "n":     return {1'b1, 8'd10};
      "r":     return {1'b1, 8'd13};
      "t":     return {1'b1, 8'd9};
      "v":     return {1'b1, 8'd11};
      Bslash:  return {1'b1, Bslash};
      Apos:    return {1'b1, Apos};
      Quote:   return {1'b1, Quote};
      "?":     return {1'b1, 8'd63};
      default: return 9'd0;
    endcase
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [5:0] pidx, logic [63:0] value,
                                    logic [19:0] start, logic [19:0] len, logic [2:0] err);
    token_t t;
    t = '{kind, pidx, value, start, len, err, 1'b0};
    if (step_tokens.size() < 4) step_tokens.push_back(t);
  endfunction

  function automatic void lex_fail(logic [2:0] code, logic [19:0] len);
    add_token(KIND_ERROR, 6'd0, 64'd0, tok_start, len, code);
    halted = 1'b1;
    lx_mode = M_IDLE;
    la_cnt = 2'd0;
  endfunction

  function automatic logic [7:0] entry_byte(int i, int k);
    case (k)
      0:       return PunctTable[i].s0;
      1:       return PunctTable[i].s1;
      default: return PunctTable[i].s2;
    endcase
  endfunction

  // false when the newest byte must be lexed again from idle
  function automatic bit match_punct(logic [7:0] b [3], int n);
    int l;
    bit ok;
    if (n >= 2 && b[0] == "/" && (b[1] == "/" || b[1] == "*")) begin
      lx_mode = (b[1] == "/") ? M_LINE : M_BLOCK;
      la_cnt = 2'd0;
      return 1'b1;
    end
    for (int i = 0; i < NumPunct; i++) begin
      l = PunctTable[i].len;
      ok = 1'b1;
      for (int k = 0; k < l && k < n; k++)
        if (entry_byte(i, k) != b[k]) ok = 1'b0;
      if (!ok) continue;
      if (l > n && n <= 2) begin
        la_byte[0] = b[0];
        la_byte[1] = (n > 1) ? b[1] : 8'd0;
        la_cnt = n[1:0];
        lx_mode = M_PUNCT;
        return 1'b1;
      end
      add_token(KIND_PUNCT, i[5:0], 64'd0, tok_start, l[19:0], ERR_NONE);
      lx_mode = M_IDLE;
      la_cnt = 2'd0;
      return l >= n;
    end
    lex_fail(ERR_UNKNOWN, 20'd1);
    return 1'b1;
  endfunction

  function automatic bit lex_byte(logic [7:0] c, logic [19:0] p);
    logic [7:0] b [3];
    logic [8:0] esc;
    int n;
    logic [19:0] span;
    span = p - tok_start;
    esc = unescape(c);
    case (lx_mode)
      M_IDLE: begin
        if (c == 8'd0) begin
          add_token(KIND_END, 6'd0, 64'd0, p, 20'd0, ERR_NONE);
          text_done = 1'b1;
          return 1'b1;
        end
        if (blank(c)) return 1'b1;
        tok_start = p;
        if (letter(c) || c == "_") begin
          lx_mode = M_IDENT;
          return 1'b1;
        end
        if (decimal(c)) begin
          lx_mode = M_NUMBER;
          num_acc = 64'(c - "0");
          return 1'b1;
        end
        if (c == ".") begin
          lex_fail(ERR_NUMBER, 20'd1);
          return 1'b1;
        end
        if (c == Quote) begin
          lx_mode = M_STRING;
          return 1'b1;
        end
        if (c == Apos) begin
          lx_mode = M_CHAR_OPEN;
          return 1'b1;
        end
        b[0] = c;
        b[1] = 8'd0;
        b[2] = 8'd0;
        return match_punct(b, 1);
      end
      M_IDENT: begin
        if (letter(c) || decimal(c) || c == "_") return 1'b1;
        add_token(KIND_IDENT, 6'd0, 64'd0, tok_start, span, ERR_NONE);
        lx_mode = M_IDLE;
        return 1'b0;
      end
      M_NUMBER: begin
        if (decimal(c)) begin
          num_acc = num_acc * 64'd10 + 64'(c - "0");
          return 1'b1;
        end
        if (letter(c)) return 1'b1;
        add_token(KIND_NUMBER, 6'd0, num_acc, tok_start, span, ERR_NONE);
        lx_mode = M_IDLE;
        return 1'b0;
      end
      M_PUNCT: begin
        n = (la_cnt > 2) ? 2 : la_cnt;
        b[0] = la_byte[0];
        b[1] = la_byte[1];
        b[2] = 8'd0;
        b[n] = c;
        return match_punct(b, n + 1);
      end
      M_LINE: begin
        if (c == 8'd0) begin
          lx_mode = M_IDLE;
          return 1'b0;
        end
        if (c == 8'd10) lx_mode = M_IDLE;
        return 1'b1;
      end
      M_BLOCK, M_BLOCK_STAR: begin
        if (c == 8'd0) begin
          lx_mode = M_IDLE;
          return 1'b0;
        end
        if (lx_mode == M_BLOCK) begin
          if (c == "*") lx_mode = M_BLOCK_STAR;
        end else if (c == "/") begin
          lx_mode = M_IDLE;
        end else if (c != "*") begin
          lx_mode = M_BLOCK;
        end
        return 1'b1;
      end
      M_STRING: begin
        if (c == 8'd0) lex_fail(ERR_STRING, span + 20'd1);
        else if (c == Quote) begin
          add_token(KIND_STREND, 6'd0, 64'd0, tok_start, span + 20'd1, ERR_NONE);
          lx_mode = M_IDLE;
        end else if (c == Bslash) lx_mode = M_STRING_ESC;
        else add_token(KIND_STRCHR, 6'd0, 64'(c), p, 20'd1, ERR_NONE);
        return 1'b1;
      end
      M_STRING_ESC: begin
        if (!esc[8]) lex_fail(ERR_STRING, span + 20'd1);
        else begin
          add_token(KIND_STRCHR, 6'd0, 64'(esc[7:0]), p - 20'd1, 20'd2, ERR_NONE);
          lx_mode = M_STRING;
        end
        return 1'b1;
      end
      M_CHAR_OPEN: begin
        if (c == 8'd0 || c == Apos) lex_fail(ERR_CHAR, span + 20'd1);
        else if (c == Bslash) lx_mode = M_CHAR_ESC;
        else begin
          lit_code = c;
          lx_mode = M_CHAR_CLOSE;
        end
        return 1'b1;
      end
      M_CHAR_ESC: begin
        if (!esc[8]) lex_fail(ERR_CHAR, span + 20'd1);
        else begin
          lit_code = esc[7:0];
          lx_mode = M_CHAR_CLOSE;
        end
        return 1'b1;
      end
      M_CHAR_CLOSE: begin
        if (c != Apos) lex_fail(ERR_CHAR, span + 20'd1);
        else begin
          add_token(KIND_CHARLIT, 6'd0, 64'(lit_code), tok_start, span + 20'd1, ERR_NONE);
          lx_mode = M_IDLE;
        end
        return 1'b1;
      end
      default: begin
        lx_mode = M_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] c);
    logic [19:0] p;
    if (halted) return;
    step_tokens.delete();
    text_done = 1'b0;
    p = byte_pos;
    if (!lex_byte(c, p) && !halted) void'(lex_byte(c, p));
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    if (text_done) clear_lexer();
    else byte_pos = p + 20'd1;
  endfunction

  // Offer one byte and hold it until the lexer takes it.
  task automatic send_byte(logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= c;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    predict_tokens(c);
    @(negedge clk_i);
  endtask

  task automatic send_src();
    foreach (src[i]) send_byte(src[i]);
    src.delete();
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_byte_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic logic [7:0] escape_letter();
    string e;
    e = "abfnrtv\\'\"?";
    return e[$urandom_range(0, e.len() - 1)];
  endfunction

  function automatic logic [7:0] word_char();
    string w;
    w = "abcxyzABCXYZ_0123456789";
    return w[$urandom_range(0, w.len() - 1)];
  endfunction

  function automatic void gen_token();
    int i;
    case ($urandom_range(0, 9))
      0, 1: begin
        src.push_back($urandom_range(0, 1) ? 8'("_") : 8'($urandom_range("a", "z")));
        repeat ($urandom_range(0, 7)) src.push_back(word_char());
      end
      2: begin
        src.push_back(8'($urandom_range("0", "9")));
        repeat ($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(18, 26))
          src.push_back($urandom_range(0, 4) ? 8'($urandom_range("0", "9")) : word_char());
      end
      3: begin
        src.push_back(Quote);
        repeat ($urandom_range(0, 6))
          if ($urandom_range(0, 2) == 0) begin
            src.push_back(Bslash);
            src.push_back(escape_letter());
          end else src.push_back(any_byte_but(Quote, Bslash));
        src.push_back(Quote);
      end
      4: begin
        src.push_back(Apos);
        if ($urandom_range(0, 2) == 0) begin
          src.push_back(Bslash);
          src.push_back(escape_letter());
        end else src.push_back(any_byte_but(Apos, Bslash));
        src.push_back(Apos);
      end
      5, 6: begin
        // entries opening with a dot or a quote never match from idle
        do i = $urandom_range(0, NumPunct - 1);
        while (PunctTable[i].s0 == "." || PunctTable[i].s0 == Quote ||
               PunctTable[i].s0 == Apos);
        for (int k = 0; k < PunctTable[i].len; k++) src.push_back(entry_byte(i, k));
        src.push_back(" ");
      end
      7: begin
        put_str("//");
        repeat ($urandom_range(0, 6)) src.push_back(any_byte_but(8'd10, 8'd10));
        src.push_back(8'd10);
      end
      8: begin
        put_str("/*");
        repeat ($urandom_range(0, 6)) src.push_back(any_byte_but("/", "/"));
        put_str("*/");
      end
      default: src.push_back(8'd0);
    endcase
    repeat ($urandom_range(0, 2)) src.push_back(8'($urandom_range(0, 1) ? 32 : $urandom_range(9, 13)));
  endfunction

  task automatic test_directed();
    put_str("a_Z9 _ 0 18446744073709551615 99999999999999999999999 12ab3 7_x(");
    put_str(") \"\\a\\b\\f\\n\\r\\t\\v\\\\\\'\\\"\\?");
    src.push_back(8'd255);
    src.push_back(8'd1);
    put_str("\" '\\n''q' '");
    src.push_back(8'd255);
    put_str("' /*/ x */ /**/ /* **/ // c\n a/=b<<=c->d--");
    src.push_back(8'd0);
    send_src();
  endtask

  task automatic test_end_in_comment();
    put_str("x /* open");
    src.push_back(8'd0);
    put_str("// tail");
    src.push_back(8'd0);
    put_str("42");
    src.push_back(8'd0);
    send_src();
  endtask

  task automatic test_random_text();
    int unsigned sent;
    sent = 0;
    while (sent < RandomBytes) begin
      gen_token();
      sent += src.size();
      send_src();
    end
  endtask

  task automatic test_backpressure();
    hold_left = 150;
    repeat (12) gen_token();
    send_src();
  endtask

  task automatic test_error_halt();
    idle_on = 1'b0;
    case ($urandom_range(0, 6))
      0: put_str(" .5");
      1: put_str(" @");
      2: put_str(" < x");
      3: put_str(" \"ab\\q\"");
      4: put_str(" ''");
      5: put_str(" 'ab'");
      default: begin
        put_str(" \"open");
        src.push_back(8'd0);
      end
    endcase
    // all of this must be swallowed silently
    put_str(" ok 12 + ");
    src.push_back(8'd0);
    send_src();
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    token_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        $error("token with none expected: kind %0d start %0d", token_kind_o, start_offset_o);
        mismatches++;
      end else begin
        e = expected_tokens.pop_front();
        if (token_kind_o !== e.kind) begin
          $error("token_kind exp %0d got %0d", e.kind, token_kind_o);
          mismatches++;
        end
        if (punct_index_o !== e.pidx) begin
          $error("punct_index exp %0d got %0d", e.pidx, punct_index_o);
          mismatches++;
        end
        if (token_value_o !== e.value) begin
          $error("token_value exp %0d got %0d", e.value, token_value_o);
          mismatches++;
        end
        if (start_offset_o !== e.start) begin
          $error("start_offset exp %0d got %0d", e.start, start_offset_o);
          mismatches++;
        end
        if (token_length_o !== e.len) begin
          $error("token_length exp %0d got %0d", e.len, token_length_o);
          mismatches++;
        end
        if (error_code_o !== e.err) begin
          $error("error_code exp %0d got %0d", e.err, error_code_o);
          mismatches++;
        end
        if (last_of_run_o !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, last_of_run_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("c_source_lexer: mismatch");
      $finish;
    end
  end

  initial begin
    clear_lexer();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_end_in_comment();
    test_random_text();
    test_backpressure();
    test_random_text();
    test_error_halt();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("c_source_lexer: match");
    else $display("c_source_lexer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/csl_pkg.sv
rtl/c_source_lexer.sv
dv/tb.sv
